[rtl/mfad_pkg.sv]
// ----------------------------------------------------------------------------
// mfad_pkg
// Shared widths, register indexes and reset values of the magnetometer anomaly detector.
// ----------------------------------------------------------------------------
package mfad_pkg;

  // Field widths
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned THR_W      = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS    = 4'd1;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RESET      = 16'd100;
  localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd3000;

endpackage

[rtl/magnet_field_anomaly_detector_core.sv]
// ----------------------------------------------------------------------------
// magnet_field_anomaly_detector_core
// Magnetometer magnitude anomaly detector with baseline and trigger cooldown.
// ----------------------------------------------------------------------------
// Each input transaction carries one signed 3-axis sample and its millisecond
// time. The block squares the three axes on one shared 16x16 multiplier (axes
// shifted through a register), takes the floor square root two radicand bits
// per cycle, then updates the baseline or the detector and loads the output
// register once it is free. The core takes no new item until it has loaded the
// result of the last one. The item that completes the baseline additionally
// runs a bit-serial divide by BASELINE_COUNT, one quotient bit per cycle, before
// the output register is loaded. The output register decouples the sides: a
// new item is taken while a result still waits to be read. Configuration
// writes are always accepted and take effect immediately.
module magnet_field_anomaly_detector_core #(
  parameter int unsigned BASELINE_COUNT = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mfad_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mfad_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [mfad_pkg::AXIS_W-1:0] sample_x_i,
  input  logic signed [mfad_pkg::AXIS_W-1:0] sample_y_i,
  input  logic signed [mfad_pkg::AXIS_W-1:0] sample_z_i,
  input  logic [mfad_pkg::TIME_W-1:0]        now_ms_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mfad_pkg::MAG_W-1:0]         magnitude_o,
  output logic                               baseline_ready_o,
  output logic                               detected_o,
  output logic                               bark_trigger_o
);
  import mfad_pkg::*;

  // Derived sizes
  localparam int unsigned CNT_W  = $clog2(BASELINE_COUNT + 1);
  localparam int unsigned SUM_W  = MAG_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned REM_W  = MAG_W + 1;
  localparam int unsigned AXES_W = 3 * AXIS_W;

  localparam logic [CNT_W-1:0]  BL_N       = CNT_W'(BASELINE_COUNT);
  localparam logic [STEP_W-1:0] SQ_LAST    = STEP_W'(3);
  localparam logic [STEP_W-1:0] ROOT_LAST  = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(SUM_W - 1);

  // State codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
    abs_axis = v[AXIS_W-1] ? AXIS_W'(~v + 1'b1) : v;
  endfunction

  // Control state
  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // Architectural state
  logic [THR_W-1:0]  thr_q;
  logic [TIME_W-1:0] cooldown_q;
  logic [SUM_W-1:0]  bl_sum_q, bl_sum_d;
  logic [CNT_W-1:0]  bl_count_q, bl_count_d;
  logic [MAG_W-1:0]  bl_value_q, bl_value_d;
  logic [TIME_W-1:0] last_trig_q, last_trig_d;

  // Datapath
  logic [AXES_W-1:0] axes_q, axes_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [SQ_W-1:0]   prod_q, prod_d;
  logic [SQ_W-1:0]   acc_q, acc_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  root_q, root_d;
  logic [CNT_W-1:0]  drem_q, drem_d;
  logic              rdy_q, rdy_d, det_q, det_d, trig_q, trig_d;
  logic [MAG_W-1:0]  mag_out_q, mag_out_d;
  logic              rdy_out_q, rdy_out_d, det_out_q, det_out_d;
  logic              trig_out_q, trig_out_d;

  // Step helpers
  logic [AXIS_W-1:0] axis_abs;
  logic [REM_W+1:0]  root_try;
  logic [REM_W+1:0]  root_trial;
  logic [CNT_W:0]    div_try;
  logic [MAG_W-1:0]  diff;
  logic [TIME_W-1:0] elapsed;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  assign axis_abs   = abs_axis(axes_q[AXIS_W-1:0]);
  assign root_try   = {rem_q, acc_q[SQ_W-1 -: 2]};
  assign root_trial = (REM_W + 2)'({root_q, 2'b01});
  assign div_try    = {drem_q, acc_q[SUM_W-1]};
  assign diff       = (root_q >= bl_value_q) ? (root_q - bl_value_q)
                                             : (bl_value_q - root_q);
  assign elapsed    = now_q - last_trig_q;
  assign sum_next   = bl_sum_q + SUM_W'(root_q);
  assign count_next = bl_count_q + 1'b1;

  // Sequence one item through square, root, update, the baseline divide once, and output load
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    bl_sum_d    = bl_sum_q;
    bl_count_d  = bl_count_q;
    bl_value_d  = bl_value_q;
    last_trig_d = last_trig_q;
    axes_d      = axes_q;
    now_d       = now_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    root_d      = root_q;
    drem_d      = drem_q;
    rdy_d       = rdy_q;
    det_d       = det_q;
    trig_d      = trig_q;
    mag_out_d   = mag_out_q;
    rdy_out_d   = rdy_out_q;
    det_out_d   = det_out_q;
    trig_out_d  = trig_out_q;

    // drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          axes_d  = {sample_z_i, sample_y_i, sample_x_i};
          now_d   = now_ms_i;
          prod_d  = '0;
          acc_d   = '0;
          step_d  = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        // square one axis, accumulate the previous square
        prod_d = SQ_W'(axis_abs) * SQ_W'(axis_abs);
        acc_d  = acc_q + prod_q;
        axes_d = {AXIS_W'(0), axes_q[AXES_W-1:AXIS_W]};
        if (step_q == SQ_LAST) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_ROOT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ROOT: begin
        // take two radicand bits, try one root bit
        acc_d = {acc_q[SQ_W-3:0], 2'b00};
        if (root_try >= root_trial) begin
          rem_d  = REM_W'(root_try - root_trial);
          root_d = {root_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(root_try);
          root_d = {root_q[MAG_W-2:0], 1'b0};
        end
        if (step_q == ROOT_LAST) begin
          state_d = ST_UPD;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_UPD: begin
        if (bl_count_q != BL_N) begin
          // accumulate baseline, no detection yet
          bl_sum_d   = sum_next;
          bl_count_d = count_next;
          rdy_d      = (count_next == BL_N);
          det_d      = 1'b0;
          trig_d     = 1'b0;
          if (count_next == BL_N) begin
            acc_d   = SQ_W'(sum_next);
            drem_d  = '0;
            step_d  = '0;
            state_d = ST_DIV;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          // compare against baseline, respect cooldown
          rdy_d  = 1'b1;
          det_d  = (diff > thr_q);
          trig_d = (diff > thr_q) && (elapsed > cooldown_q);
          if ((diff > thr_q) && (elapsed > cooldown_q)) begin
            last_trig_d = now_q;
          end
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        // restoring divide by the baseline count, one quotient bit a cycle
        if (div_try >= (CNT_W + 1)'(BL_N)) begin
          drem_d = CNT_W'(div_try - (CNT_W + 1)'(BL_N));
          acc_d  = {acc_q[SQ_W-2:0], 1'b1};
        end else begin
          drem_d = CNT_W'(div_try);
          acc_d  = {acc_q[SQ_W-2:0], 1'b0};
        end
        if (step_q == DIV_LAST) begin
          bl_value_d = acc_d[MAG_W-1:0];
          state_d    = ST_FIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          mag_out_d   = root_q;
          rdy_out_d   = rdy_q;
          det_out_d   = det_q;
          trig_out_d  = trig_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= THR_RESET;
      cooldown_q  <= COOLDOWN_RESET;
      bl_sum_q    <= '0;
      bl_count_q  <= '0;
      bl_value_q  <= '0;
      last_trig_q <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      bl_sum_q    <= bl_sum_d;
      bl_count_q  <= bl_count_d;
      bl_value_q  <= bl_value_d;
      last_trig_q <= last_trig_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_DIFF_THRESHOLD) begin
          thr_q <= cfg_data_i[THR_W-1:0];
        end else if (cfg_index_i == REG_COOLDOWN_MS) begin
          cooldown_q <= cfg_data_i[TIME_W-1:0];
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    axes_q     <= axes_d;
    now_q      <= now_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    drem_q     <= drem_d;
    rdy_q      <= rdy_d;
    det_q      <= det_d;
    trig_q     <= trig_d;
    mag_out_q  <= mag_out_d;
    rdy_out_q  <= rdy_out_d;
    det_out_q  <= det_out_d;
    trig_out_q <= trig_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign magnitude_o      = mag_out_q;
  assign baseline_ready_o = rdy_out_q;
  assign detected_o       = det_out_q;
  assign bark_trigger_o   = trig_out_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_count_q <= BL_N)
    else $error("baseline count ran past BASELINE_COUNT");

  a_trig_needs_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bark_trigger_o |-> detected_o)
    else $error("trigger without detection");

  a_det_needs_baseline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && detected_o |-> baseline_ready_o)
    else $error("detection before baseline formed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core accepted a transaction while busy");

endmodule

[tb/sv/magnet_field_anomaly_detector_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnet_field_anomaly_detector_core_tb
// Self-checking bench for the magnetometer anomaly detector. Drives sample and
// register transactions, predicts each reading (magnitude, baseline, detection
// and cooldown-gated trigger) and compares it with the block's result stream.
// ----------------------------------------------------------------------------
module magnet_field_anomaly_detector_core_tb;
  import mfad_pkg::*;

  localparam int BASELINE_N     = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 64;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED = REG_COOLDOWN_MS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP          = '1;

  // Baseline samples: axis extremes, zero, and moderate field readings
  localparam int BASE_X [16] = '{-32768, 32767, 0, -1, 1, 0, 3000, 5000,
                                 -4000, 1234, -300, 6000, 7, -20000, 2500, -8};
  localparam int BASE_Y [16] = '{-32768, 32767, 0, -1, 0, -32768, 4000, -2000,
                                 3000, -5678, 400, 0, 24, 100, 2500, -8};
  localparam int BASE_Z [16] = '{-32768, 32767, 0, -1, 0, 0, 0, 1000,
                                 0, 910, -1200, -6000, -60, 5, 2500, 8};
  localparam int AXIS_EXTREMES [5] = '{-32768, -1, 0, 1, 32767};

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             baseline_ready;
    logic             detected;
    logic             bark_trigger;
  } reading_t;

  // Predicts readings and checks the result stream against them
  class anomaly_scoreboard;
    logic [THR_W-1:0]  diff_threshold;
    logic [TIME_W-1:0] cooldown_ms;
    logic [31:0]       baseline_sum;
    int                baseline_taken;
    logic [MAG_W-1:0]  baseline_mean;
    logic [TIME_W-1:0] last_bark_ms;
    reading_t          expected_readings [$];
    int                readings_seen;
    int                errors;

    function void power_on();
      diff_threshold = THR_RESET;
      cooldown_ms    = COOLDOWN_RESET;
      baseline_sum   = '0;
      baseline_taken = 0;
      baseline_mean  = '0;
      last_bark_ms   = '0;
      readings_seen  = 0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DIFF_THRESHOLD: diff_threshold = data[THR_W-1:0];
        REG_COOLDOWN_MS:    cooldown_ms    = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    // Build the root one bit at a time, keeping each bit whose square still fits
    static function logic [MAG_W-1:0] floor_sqrt(logic [63:0] v);
      logic [MAG_W-1:0] root;
      logic [MAG_W-1:0] trial;
      root = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
        trial = root | (MAG_W'(1) << b);
        if (64'(trial) * 64'(trial) <= v) root = trial;
      end
      return root;
    endfunction

    function void note_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                              logic signed [AXIS_W-1:0] z, logic [TIME_W-1:0] now);
      logic [63:0]      energy;
      logic [MAG_W-1:0] dev;
      reading_t         r;
      energy = 64'(longint'(x) * longint'(x) + longint'(y) * longint'(y)
                   + longint'(z) * longint'(z));
      r.magnitude    = floor_sqrt(energy);
      r.detected     = 1'b0;
      r.bark_trigger = 1'b0;
      if (baseline_taken < BASELINE_N) begin
        // Accumulate; the sample that completes the set forms the mean
        baseline_sum += 32'(r.magnitude);
        baseline_taken++;
        if (baseline_taken == BASELINE_N) baseline_mean = MAG_W'(baseline_sum / BASELINE_N);
      end else begin
        dev = (r.magnitude >= baseline_mean) ? r.magnitude - baseline_mean
                                             : baseline_mean - r.magnitude;
        r.detected = (dev > diff_threshold);
        // Elapsed time wraps modulo 2^32
        if (r.detected && (now - last_bark_ms) > cooldown_ms) begin
          r.bark_trigger = 1'b1;
          last_bark_ms   = now;
        end
      end
      r.baseline_ready = (baseline_taken >= BASELINE_N);
      expected_readings.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] reading %0d: %s got %0d expected %0d", $time, readings_seen, what,
               got, want);
    endtask

    task check_result(logic [MAG_W-1:0] magnitude, logic baseline_ready, logic detected,
                      logic bark_trigger);
      reading_t want;
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected reading, magnitude", 32'(magnitude), '0);
      end else begin
        want = expected_readings.pop_front();
        if (magnitude !== want.magnitude)
          report_mismatch("magnitude", 32'(magnitude), 32'(want.magnitude));
        if (baseline_ready !== want.baseline_ready)
          report_mismatch("baseline_ready", 32'(baseline_ready), 32'(want.baseline_ready));
        if (detected !== want.detected)
          report_mismatch("detected", 32'(detected), 32'(want.detected));
        if (bark_trigger !== want.bark_trigger)
          report_mismatch("bark_trigger", 32'(bark_trigger), 32'(want.bark_trigger));
      end
      readings_seen++;
    endtask
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [AXIS_W-1:0]  sample_x_i  = '0;
  logic signed [AXIS_W-1:0]  sample_y_i  = '0;
  logic signed [AXIS_W-1:0]  sample_z_i  = '0;
  logic [TIME_W-1:0]         now_ms_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [MAG_W-1:0]          magnitude_o;
  logic                      baseline_ready_o;
  logic                      detected_o;
  logic                      bark_trigger_o;

  anomaly_scoreboard sb;
  int                stall_pct    = 0;
  int                stall_left   = 0;
  int                quiet_cycles = 0;
  logic [TIME_W-1:0] clock_ms     = '0;

  magnet_field_anomaly_detector_core #(
    .BASELINE_COUNT(BASELINE_N)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_x_i       (sample_x_i),
    .sample_y_i       (sample_y_i),
    .sample_z_i       (sample_z_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .magnitude_o      (magnitude_o),
    .baseline_ready_o (baseline_ready_o),
    .detected_o       (detected_o),
    .bark_trigger_o   (bark_trigger_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: stall single cycles or in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Observe every transaction at the rising edge; watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_sample(sample_x_i, sample_y_i, sample_z_i, now_ms_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(magnitude_o, baseline_ready_o, detected_o, bark_trigger_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o)
          || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic signed [AXIS_W-1:0] axis_of(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return AXIS_W'(v);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Present one transaction after an optional idle gap; drop valid once taken
  task automatic send_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                             logic signed [AXIS_W-1:0] z, logic [TIME_W-1:0] now, int gap);
    @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    sample_y_i <= y;
    sample_z_i <= z;
    now_ms_i   <= now;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_readings.size() != 0) @(negedge clk_i);
  endtask

  // Reprogram while idle, then stream random samples under the given idling
  task automatic run_phase(int n, int send_pct, int recv_pct, logic [THR_W-1:0] thr,
                           logic [TIME_W-1:0] cd);
    logic signed [AXIS_W-1:0] ax [3];
    logic [TIME_W-1:0]        step_span;
    int                       span;
    int                       target;
    int                       a;
    int                       gap;
    wait_drain();
    cfg_write(REG_DIFF_THRESHOLD, CFG_DATA_W'(thr));
    cfg_write(REG_COOLDOWN_MS, cd);
    cfg_write(CFG_IDX_W'($urandom_range(int'(IDX_TOP), int'(IDX_FIRST_UNUSED))), $urandom);
    stall_pct = recv_pct;
    span      = ((thr > 1000) ? 1000 : int'(thr)) + 8;
    step_span = (cd > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : cd / 3 + 2;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int k = 0; k < 3; k++) ax[k] = AXIS_W'($urandom);
        end
        4: begin
          for (int k = 0; k < 3; k++) ax[k] = axis_of(AXIS_EXTREMES[$urandom_range(0, 4)]);
        end
        default: begin
          // Magnitude near the baseline, straddling the threshold on both sides
          target = int'(sb.baseline_mean) + int'($urandom_range(0, 2 * span)) - span;
          a = $urandom_range(0, 2);
          for (int k = 0; k < 3; k++) ax[k] = axis_of(int'($urandom_range(0, 6)) - 3);
          ax[a] = axis_of($urandom_range(0, 1) ? -target : target);
        end
      endcase
      case ($urandom_range(0, 9))
        0: clock_ms = $urandom;
        1: ;
        default: clock_ms += $urandom_range(0, step_span);
      endcase
      gap = ($urandom_range(0, 99) < send_pct) ? $urandom_range(1, 40) : 0;
      send_sample(ax[0], ax[1], ax[2], clock_ms, gap);
    end
  endtask

  initial begin
    int b;
    int thr;
    sb = new();
    sb.power_on();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the baseline, extremes included, with reset register values
    for (int i = 0; i < BASELINE_N; i++)
      send_sample(axis_of(BASE_X[i]), axis_of(BASE_Y[i]), axis_of(BASE_Z[i]),
                  TIME_W'(i * 10), 0);
    wait_drain();
    b   = int'(sb.baseline_mean);
    thr = int'(THR_RESET);

    // Deviation equal to threshold, then cooldown edge, wrap and negative side
    send_sample(axis_of(b + thr), '0, '0, 32'd5000, 0);
    send_sample(axis_of(b + thr + 1), '0, '0, 32'd3000, 0);
    send_sample('0, axis_of(b + thr + 1), '0, 32'd3001, 0);
    send_sample('0, '0, axis_of(-(b + thr + 1)), 32'd3002, 0);
    send_sample(axis_of(b - thr - 1), '0, '0, 32'd6002, 0);
    send_sample(axis_of(b - thr - 1), '0, '0, 32'd0, 0);
    send_sample(axis_of(b - thr - 1), '0, '0, 32'hFFFF_FFFF, 0);

    // Zero threshold and zero cooldown: repeat time must not retrigger
    wait_drain();
    cfg_write(REG_DIFF_THRESHOLD, '0);
    cfg_write(REG_COOLDOWN_MS, '0);
    send_sample(axis_of(b + 1), '0, '0, 32'd5, 0);
    send_sample(axis_of(b + 1), '0, '0, 32'd5, 0);
    send_sample('0, '0, axis_of(b), 32'd5, 0);

    // Maximum registers; unmapped writes of zero must leave them untouched
    wait_drain();
    cfg_write(REG_DIFF_THRESHOLD, '1);
    cfg_write(REG_COOLDOWN_MS, '1);
    cfg_write(IDX_TOP, '0);
    cfg_write(IDX_FIRST_UNUSED, '0);
    send_sample(axis_of(-32768), axis_of(-32768), axis_of(-32768), '0, 0);

    // Random phases across idling patterns and register settings
    run_phase(100, 0, 0, THR_W'(100), TIME_W'(200));
    run_phase(100, 58, 0, THR_W'($urandom_range(0, 300)), TIME_W'($urandom_range(0, 1000)));
    run_phase(100, 0, 58, '0, '0);
    run_phase(60, 21, 21, THR_W'($urandom), $urandom);
    run_phase(40, 21, 21, '1, '1);
    run_phase(40, 0, 0, THR_W'(40), TIME_W'(1));

    // Drain, let the block settle, then judge
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.expected_readings.size() != 0)
      sb.report_mismatch("readings never delivered", sb.expected_readings.size(), '0);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mfad_pkg.sv
rtl/magnet_field_anomaly_detector_core.sv
tb/sv/magnet_field_anomaly_detector_core_tb.sv
